/* hw/rtl/rtlin_pkg.sv */
// ----------------------------------------------------------------------------
// rtlin_pkg
// Shared widths, constants and coefficient tables of the ratiometric
// thermistor linearizer.
// ----------------------------------------------------------------------------
package rtlin_pkg;

	// converter sample width
	localparam int SAMPLE_BITS = 12;

	// reference span is taken modulo 2^16
	localparam int SPAN_W = 16;

	// ideal 2.5 V count and Q16 gain layout
	localparam int REF_COUNT = 3103;
	localparam int REF_BITS  = 12;
	localparam int GAIN_FRAC = 16;
	localparam int GAIN_W    = REF_BITS + GAIN_FRAC;

	// product and corrected count widths
	localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
	localparam int SCALE_W = PROD_W - GAIN_FRAC;
	localparam int DATA_W  = 32;

	// dividend of the gain division: REF_COUNT in Q16
	localparam logic [GAIN_W-1:0] GAIN_DIVIDEND = GAIN_W'(REF_COUNT) << GAIN_FRAC;

	// region thresholds on the signed corrected count
	localparam logic signed [DATA_W-1:0] TH_HOT  = 32'sd3180;
	localparam logic signed [DATA_W-1:0] TH_WARM = 32'sd1400;
	localparam logic signed [DATA_W-1:0] TH_MILD = 32'sd256;

	// polynomial segment
	typedef enum logic [1:0] {
		SEG_HOT,
		SEG_WARM,
		SEG_MILD,
		SEG_COLD
	} seg_t;

	// side data that travels with an item through the divider
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic [SAMPLE_BITS-1:0] rlo;
		logic                   zero;
	} div_side_t;

	// linear coefficient, sign folded in
	function automatic logic [DATA_W-1:0] lin_coef(input seg_t seg);
		case (seg)
			SEG_HOT:  return 32'h0000_72B0;
			SEG_WARM: return -32'h0000_05D7;
			SEG_MILD: return -32'h0000_1B57;
			SEG_COLD: return -32'h0000_9A23;
			default:  return '0;
		endcase
	endfunction

	// square coefficient, sign folded in
	function automatic logic [DATA_W-1:0] quad_coef(input seg_t seg);
		case (seg)
			SEG_HOT:  return -32'd4;
			SEG_WARM: return 32'd0;
			SEG_MILD: return 32'd4;
			SEG_COLD: return 32'h0000_0048;
			default:  return '0;
		endcase
	endfunction

	// constant term, Q16 truncated
	function automatic logic [DATA_W-1:0] poly_const(input seg_t seg);
		case (seg)
			SEG_HOT:  return -32'd47862906;
			SEG_WARM: return 32'h0047_ECCB;
			SEG_MILD: return 32'd8029470;
			SEG_COLD: return 32'd12247367;
			default:  return '0;
		endcase
	endfunction

endpackage

/* hw/rtl/ratiometric_thermistor_linearizer.sv */
// ----------------------------------------------------------------------------
// ratiometric_thermistor_linearizer
// Reference-corrected thermistor count mapped to Q16 degrees.
// ----------------------------------------------------------------------------
// An item is taken at every edge with start high; busy never rises, so one
// item per cycle is sustained. Each result shows on temperature_q16 and
// span_error for one cycle with done high, in order. The receiver cannot
// hold results off and must take them. Each item passes the input register,
// then the gain divider, which resolves one of its 28 quotient bits per
// pipeline stage, then the product stage, the count stage and the three
// polynomial stages.
module ratiometric_thermistor_linearizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rtlin_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic [rtlin_pkg::SAMPLE_BITS-1:0]    ref_high,
	input  logic [rtlin_pkg::SAMPLE_BITS-1:0]    ref_low,
	output logic                                 done,
	output logic signed [rtlin_pkg::DATA_W-1:0]  temperature_q16,
	output logic                                 span_error
);
	import rtlin_pkg::*;

	logic              vld_s1;
	logic [SPAN_W-1:0] span_s1;
	div_side_t         side_s1;
	logic [SPAN_W-1:0] span_in;

	logic              div_vld;
	logic [GAIN_W-1:0] div_gain;
	div_side_t         div_side;

	logic              vld_s2, vld_s3;
	logic [PROD_W-1:0] psmp_s2, prlo_s2;
	logic              zero_s2, zero_s3;
	logic [DATA_W-1:0] count_s3;
	logic [SCALE_W:0]  count_diff;
	logic [DATA_W-1:0] temp_out;

	assign busy = 1'b0;

	// span modulo 2^16
	assign span_in = SPAN_W'(ref_high) - SPAN_W'(ref_low);

	// valid bits of the input, product and count stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= div_vld;
			vld_s3 <= vld_s2;
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		span_s1      <= span_in;
		side_s1.smp  <= sample;
		side_s1.rlo  <= ref_low;
		side_s1.zero <= (span_in == '0);
	end

	// gain = REF_COUNT in Q16 over span
	rtlin_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_span   (span_s1),
		.in_side   (side_s1),
		.out_valid (div_vld),
		.out_gain  (div_gain),
		.out_side  (div_side)
	);

	// scale sample and low reference by the gain
	always_ff @(posedge clk) begin
		psmp_s2 <= PROD_W'(div_side.smp) * PROD_W'(div_gain);
		prlo_s2 <= PROD_W'(div_side.rlo) * PROD_W'(div_gain);
		zero_s2 <= div_side.zero;
	end

	// corrected count, signed
	assign count_diff = {1'b0, psmp_s2[PROD_W-1:GAIN_FRAC]}
	                  - {1'b0, prlo_s2[PROD_W-1:GAIN_FRAC]};

	always_ff @(posedge clk) begin
		count_s3 <= DATA_W'($signed(count_diff));
		zero_s3  <= zero_s2;
	end

	// segment polynomial and output register
	rtlin_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_count  (count_s3),
		.in_zero   (zero_s3),
		.out_valid (done),
		.out_temp  (temp_out),
		.out_error (span_error)
	);

	assign temperature_q16 = $signed(temp_out);

endmodule

/* hw/rtl/rtlin_divider.sv */
// ----------------------------------------------------------------------------
// rtlin_divider
// Pipelined restoring divider: GAIN_DIVIDEND / span, one quotient bit per
// stage, with side data and valid carried alongside.
// ----------------------------------------------------------------------------
module rtlin_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rtlin_pkg::SPAN_W-1:0]  in_span,
	input  rtlin_pkg::div_side_t          in_side,
	output logic                          out_valid,
	output logic [rtlin_pkg::GAIN_W-1:0]  out_gain,
	output rtlin_pkg::div_side_t          out_side
);
	import rtlin_pkg::*;

	// stage registers, index k holds the item after stage k+1
	logic              vld_s  [GAIN_W];
	logic [GAIN_W-1:0] quo_s  [GAIN_W];
	div_side_t         side_s [GAIN_W];
	logic [SPAN_W-1:0] rem_s  [GAIN_W-1];
	logic [SPAN_W-1:0] span_s [GAIN_W-1];

	// next-stage values
	logic [SPAN_W-1:0] rem_nx [GAIN_W];
	logic              bit_nx [GAIN_W];

	// bring down one dividend bit and trial-subtract the span
	function automatic logic [SPAN_W:0] div_step(input logic [SPAN_W-1:0] rem,
			input logic dbit, input logic [SPAN_W-1:0] span);
		logic [SPAN_W:0] trial;
		logic [SPAN_W:0] diff;
		logic            q;
		trial = {rem, dbit};
		diff  = trial - {1'b0, span};
		q     = (trial >= {1'b0, span});
		return {q, q ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0]};
	endfunction

	// first stage works on the incoming span, the rest on the stage registers
	always_comb begin
		{bit_nx[0], rem_nx[0]} = div_step('0, GAIN_DIVIDEND[GAIN_W-1], in_span);
		for (int i = 1; i < GAIN_W; i++) begin
			{bit_nx[i], rem_nx[i]} = div_step(rem_s[i-1], GAIN_DIVIDEND[GAIN_W-1-i],
				span_s[i-1]);
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GAIN_W; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < GAIN_W; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// advance remainder, quotient and side data
	always_ff @(posedge clk) begin
		quo_s[0]  <= GAIN_W'(bit_nx[0]);
		side_s[0] <= in_side;
		rem_s[0]  <= rem_nx[0];
		span_s[0] <= in_span;
		for (int i = 1; i < GAIN_W; i++) begin
			quo_s[i]  <= {quo_s[i-1][GAIN_W-2:0], bit_nx[i]};
			side_s[i] <= side_s[i-1];
		end
		for (int i = 1; i < GAIN_W-1; i++) begin
			rem_s[i]  <= rem_nx[i];
			span_s[i] <= span_s[i-1];
		end
	end

	assign out_valid = vld_s[GAIN_W-1];
	assign out_gain  = quo_s[GAIN_W-1];
	assign out_side  = side_s[GAIN_W-1];

endmodule

/* hw/rtl/rtlin_poly.sv */
// ----------------------------------------------------------------------------
// rtlin_poly
// Three-stage evaluation of the segment polynomial on the corrected count,
// ending in the output register.
// ----------------------------------------------------------------------------
module rtlin_poly (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rtlin_pkg::DATA_W-1:0]  in_count,
	input  logic                          in_zero,
	output logic                          out_valid,
	output logic [rtlin_pkg::DATA_W-1:0]  out_temp,
	output logic                          out_error
);
	import rtlin_pkg::*;

	logic              vld_s1, vld_s2, vld_s3;
	logic              zero_s1, zero_s2;
	seg_t              seg_s1, seg_s2;
	logic [DATA_W-1:0] sq_s1, lin_s1;
	logic [DATA_W-1:0] quad_s2, lin_s2;
	logic [DATA_W-1:0] temp_s3;
	logic              err_s3;
	seg_t              seg_in;

	// pick the segment by signed thresholds
	always_comb begin
		if ($signed(in_count) > TH_HOT)       seg_in = SEG_HOT;
		else if ($signed(in_count) > TH_WARM) seg_in = SEG_WARM;
		else if ($signed(in_count) > TH_MILD) seg_in = SEG_MILD;
		else                                  seg_in = SEG_COLD;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// square and linear term, then scaled square, then sum
	always_ff @(posedge clk) begin
		sq_s1   <= in_count * in_count;
		lin_s1  <= in_count * lin_coef(seg_in);
		seg_s1  <= seg_in;
		zero_s1 <= in_zero;

		quad_s2 <= sq_s1 * quad_coef(seg_s1);
		lin_s2  <= lin_s1;
		seg_s2  <= seg_s1;
		zero_s2 <= zero_s1;

		temp_s3 <= zero_s2 ? '0 : (quad_s2 + lin_s2 + poly_const(seg_s2));
		err_s3  <= zero_s2;
	end

	assign out_valid = vld_s3;
	assign out_temp  = temp_s3;
	assign out_error = err_s3;

endmodule
